>>> hdl/bps_pkg.sv
package bps_pkg;

  localparam int unsigned CFG_W = 16;
  localparam int unsigned MS_W  = 32;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_BEEP    = 3'd1,
    OP_LONG    = 3'd2,
    OP_PATTERN = 3'd3,
    OP_STOP    = 3'd4,
    OP_HB_SET  = 3'd5,
    OP_ON      = 3'd6,
    OP_OFF     = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    PAT_NONE      = 3'd0,
    PAT_SUCCESS   = 3'd1,
    PAT_ERROR     = 3'd2,
    PAT_WARNING   = 3'd3,
    PAT_STARTUP   = 3'd4,
    PAT_EMERGENCY = 3'd5
  } pat_e;

  typedef enum logic [2:0] {
    REG_SHORT     = 3'd0,
    REG_GAP       = 3'd1,
    REG_LONG      = 3'd2,
    REG_HB_PERIOD = 3'd3,
    REG_HB_PULSE  = 3'd4
  } reg_e;

  // Shape of the note table being filled
  typedef enum logic [2:0] {
    LD_BEEP,
    LD_LONG,
    LD_ERROR,
    LD_STARTUP,
    LD_EMERGENCY
  } load_e;

  typedef struct packed {
    logic             level;
    logic [CFG_W-1:0] length;
  } note_t;

  typedef struct packed {
    logic [2:0]      operation;
    logic [7:0]      beep_count;
    logic [MS_W-1:0] tone_ms;
    logic [2:0]      pattern_code;
    logic            heartbeat_on;
  } in_item_t;

  typedef struct packed {
    logic buzzer_level;
    logic busy_res;
  } out_item_t;

endpackage

>>> hdl/bps_ram.sv
module bps_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/buzzer_pattern_sequencer.sv
// Buzzer pattern sequencer.
// Input channel (in_valid_i/in_ready_o/in_data_i) takes one command per beat:
// tick, beep, long tone, pattern, stop, heartbeat set, force on, force off.
// Output channel (out_valid_o/out_ready_i/out_data_o) returns one beat per
// command: the buzzer level and whether a note sequence is running.
// Registers (short, gap, long, heartbeat period, heartbeat pulse) sit on the
// APB port at byte addresses 0, 4, 8, 12, 16; write them only while idle.
// A command takes the block out of idle until its result is in the output
// register; in_ready_o is low meanwhile. States each command passes through:
//   force, stop, heartbeat set, plain tick: EMIT
//   tick that moves to the next note: RD, APPLY, EMIT (note table read through the RAM)
//   beep or pattern: FILL, one step per table entry (at most MAX_NOTES), then EMIT
//   long tone: DIV for two multiply passes by the tick period's reciprocal, FILL, EMIT
// The note table lives in a single-port-write, registered-read RAM, filled one
// entry per cycle. Reset clears all control state and the registers return to
// their defaults; the table itself needs no clearing. When the receiver
// stalls, the result holds in the output register and the next command is
// still taken; its result waits until that register frees up.
module buzzer_pattern_sequencer
  import bps_pkg::*;
#(
  parameter int unsigned MAX_NOTES      = 16,
  parameter int unsigned TICK_PERIOD_MS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IW    = $clog2(MAX_NOTES + 1);
  localparam int unsigned AW    = $clog2(MAX_NOTES);
  localparam int unsigned NB    = MAX_NOTES / 2;
  // Reciprocal of the tick period, exact floor for every 32-bit duration
  localparam int unsigned SHIFT = MS_W + $clog2(TICK_PERIOD_MS);
  localparam int unsigned KW    = (MS_W + 2) / 2;
  localparam int unsigned PW    = MS_W + 2 * KW;
  localparam logic [7:0]       NB_CNT   = 8'(NB);
  localparam logic [IW-1:0]    NB_LEN   = IW'(2 * NB);
  localparam logic [63:0]      RECIP_W  = ((64'd1 << SHIFT) + 64'(TICK_PERIOD_MS) - 64'd1) /
                                          64'(TICK_PERIOD_MS);
  localparam logic [2*KW-1:0]  RECIP    = RECIP_W[2*KW-1:0];

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DIV   = 6'b000010,
    ST_FILL  = 6'b000100,
    ST_RD    = 6'b001000,
    ST_APPLY = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [CFG_W-1:0]  short_q, gap_q, long_q, hb_period_q, hb_pulse_q;
  logic [IW-1:0]     seq_len_q, seq_len_d;
  logic [IW-1:0]     step_index_q, step_index_d;
  logic [CFG_W-1:0]  step_rem_q, step_rem_d;
  logic              running_q, running_d;
  logic              looping_q, looping_d;
  logic              pulse_en_q, pulse_en_d;
  logic [CFG_W-1:0]  pulse_cnt_q, pulse_cnt_d;
  logic              pulse_snd_q, pulse_snd_d;
  logic              pin_q, pin_d;
  load_e             kind_q, kind_d;
  logic [AW-1:0]     fill_k_q, fill_k_d;
  logic [MS_W-1:0]   div_q, div_d;
  logic [MS_W+KW-1:0] prod_lo_q, prod_lo_d;
  logic              mul_hi_q, mul_hi_d;
  logic [CFG_W-1:0]  long_len_q, long_len_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_data_q, out_data_d;

  logic              cfg_we;
  note_t             ram_wdata, ram_rdata, entry0;
  logic              ram_we;
  logic [8:0]        cnt2m1;
  logic [IW-1:0]     beep_len;
  logic [IW-1:0]     seq_len_m1;
  logic [IW-1:0]     idx_inc;
  logic [CFG_W-1:0]  rem_dec;
  logic [CFG_W-1:0]  cnt_inc;
  logic [KW-1:0]     mul_b;
  logic [MS_W+KW-1:0] mul_p;
  logic [PW-1:0]     prod_sum;
  logic [CFG_W-1:0]  quot;

  function automatic note_t note_entry(input load_e kind, input logic [AW-1:0] k);
    note_t e;
    e.level = ~k[0];
    unique case (kind)
      LD_BEEP:      e.length = k[0] ? gap_q : short_q;
      LD_LONG:      e.length = long_len_q;
      LD_ERROR:     e.length = k[0] ? gap_q : long_q;
      LD_STARTUP:   e.length = k[0] ? gap_q : ((k == '0) ? long_q : short_q);
      LD_EMERGENCY: e.length = short_q;
      default:      e.length = short_q;
    endcase
    return e;
  endfunction

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_q     <= CFG_W'(10);
      gap_q       <= CFG_W'(10);
      long_q      <= CFG_W'(50);
      hb_period_q <= CFG_W'(100);
      hb_pulse_q  <= CFG_W'(5);
    end else if (cfg_we) begin
      unique case (reg_e'(paddr[4:2]))
        REG_SHORT:     short_q     <= pwdata[CFG_W-1:0];
        REG_GAP:       gap_q       <= pwdata[CFG_W-1:0];
        REG_LONG:      long_q      <= pwdata[CFG_W-1:0];
        REG_HB_PERIOD: hb_period_q <= pwdata[CFG_W-1:0];
        REG_HB_PULSE:  hb_pulse_q  <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_e'(paddr[4:2]))
      REG_SHORT:     prdata = {16'd0, short_q};
      REG_GAP:       prdata = {16'd0, gap_q};
      REG_LONG:      prdata = {16'd0, long_q};
      REG_HB_PERIOD: prdata = {16'd0, hb_period_q};
      REG_HB_PULSE:  prdata = {16'd0, hb_pulse_q};
      default:       prdata = 32'd0;
    endcase
  end

  // ---------------- note table ----------------
  assign ram_wdata = note_entry(kind_q, fill_k_q);
  assign entry0    = note_entry(kind_q, '0);

  bps_ram #(
    .WIDTH ($bits(note_t)),
    .DEPTH (MAX_NOTES)
  ) u_note_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fill_k_q),
    .wdata_i (ram_wdata),
    .raddr_i (step_index_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // ---------------- shared datapath ----------------
  // Beeps alternate with gaps; at most MAX_NOTES/2 beeps, a trailing gap
  // when the count overflows.
  assign cnt2m1     = {in_data_i.beep_count, 1'b0} - 9'd1;
  assign beep_len   = (in_data_i.beep_count > NB_CNT) ? NB_LEN :
                      (in_data_i.beep_count == 8'd0) ? '0 : cnt2m1[IW-1:0];
  assign seq_len_m1 = seq_len_q - IW'(1);
  assign idx_inc    = step_index_q + IW'(1);
  assign rem_dec    = (step_rem_q != '0) ? step_rem_q - CFG_W'(1) : step_rem_q;
  assign cnt_inc    = pulse_cnt_q + CFG_W'(1);

  // Divide by the tick period as a multiply by its reciprocal: low half of
  // the constant on the first pass, high half on the second
  assign mul_b    = mul_hi_q ? RECIP[2*KW-1:KW] : RECIP[KW-1:0];
  assign mul_p    = (MS_W + KW)'(div_q) * (MS_W + KW)'(mul_b);
  assign prod_sum = PW'(prod_lo_q) + {mul_p, {KW{1'b0}}};
  assign quot     = prod_sum[SHIFT +: CFG_W];

  always_comb begin
    state_d      = state_q;
    seq_len_d    = seq_len_q;
    step_index_d = step_index_q;
    step_rem_d   = step_rem_q;
    running_d    = running_q;
    looping_d    = looping_q;
    pulse_en_d   = pulse_en_q;
    pulse_cnt_d  = pulse_cnt_q;
    pulse_snd_d  = pulse_snd_q;
    pin_d        = pin_q;
    kind_d       = kind_q;
    fill_k_d     = fill_k_q;
    div_d        = div_q;
    prod_lo_d    = prod_lo_q;
    mul_hi_d     = mul_hi_q;
    long_len_d   = long_len_q;
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    ram_we       = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EMIT;
          unique case (op_e'(in_data_i.operation))
            OP_TICK: begin
              if (running_q) begin
                step_rem_d = rem_dec;
                if (rem_dec == '0) begin
                  if (idx_inc >= seq_len_q) begin
                    if (looping_q) begin
                      step_index_d = '0;
                      state_d      = ST_RD;
                    end else begin
                      step_index_d = idx_inc;
                      running_d    = 1'b0;
                      pin_d        = 1'b0;
                    end
                  end else begin
                    step_index_d = idx_inc;
                    state_d      = ST_RD;
                  end
                end
              end else if (pulse_en_q) begin
                pulse_cnt_d = cnt_inc;
                if (!pulse_snd_q) begin
                  if (cnt_inc >= hb_period_q) begin
                    pin_d       = 1'b1;
                    pulse_snd_d = 1'b1;
                    pulse_cnt_d = '0;
                  end
                end else if (cnt_inc >= hb_pulse_q) begin
                  pin_d       = 1'b0;
                  pulse_snd_d = 1'b0;
                  pulse_cnt_d = '0;
                end
              end
            end
            OP_BEEP: begin
              seq_len_d = beep_len;
              if (beep_len == '0) begin
                running_d = 1'b0;
                pin_d     = 1'b0;
              end else begin
                kind_d   = LD_BEEP;
                fill_k_d = '0;
                state_d  = ST_FILL;
              end
            end
            OP_LONG: begin
              div_d    = in_data_i.tone_ms;
              mul_hi_d = 1'b0;
              state_d  = ST_DIV;
            end
            OP_PATTERN: begin
              fill_k_d = '0;
              unique case (pat_e'(in_data_i.pattern_code))
                PAT_NONE: begin
                  running_d = 1'b0;
                  looping_d = 1'b0;
                  seq_len_d = '0;
                  pin_d     = 1'b0;
                end
                PAT_SUCCESS: begin
                  kind_d    = LD_BEEP;
                  seq_len_d = IW'(3);
                  state_d   = ST_FILL;
                end
                PAT_ERROR: begin
                  kind_d    = LD_ERROR;
                  seq_len_d = IW'(5);
                  state_d   = ST_FILL;
                end
                PAT_WARNING: begin
                  kind_d    = LD_BEEP;
                  seq_len_d = IW'(5);
                  state_d   = ST_FILL;
                end
                PAT_STARTUP: begin
                  kind_d    = LD_STARTUP;
                  seq_len_d = IW'(5);
                  state_d   = ST_FILL;
                end
                PAT_EMERGENCY: begin
                  kind_d    = LD_EMERGENCY;
                  seq_len_d = IW'(2);
                  state_d   = ST_FILL;
                end
                default: ;
              endcase
            end
            OP_STOP: begin
              running_d = 1'b0;
              looping_d = 1'b0;
              seq_len_d = '0;
              pin_d     = 1'b0;
            end
            OP_HB_SET: begin
              pulse_en_d  = in_data_i.heartbeat_on;
              pulse_cnt_d = '0;
              pulse_snd_d = 1'b0;
            end
            OP_ON:   pin_d = 1'b1;
            OP_OFF:  pin_d = 1'b0;
            default: pin_d = 1'b0;
          endcase
        end
      end
      ST_DIV: begin
        if (mul_hi_q) begin
          // Quotient truncated to 16 bits, raised to one when zero
          long_len_d = (quot == '0) ? CFG_W'(1) : quot;
          seq_len_d  = IW'(1);
          kind_d     = LD_LONG;
          fill_k_d   = '0;
          state_d    = ST_FILL;
        end else begin
          prod_lo_d = mul_p;
          mul_hi_d  = 1'b1;
        end
      end
      ST_FILL: begin
        ram_we = 1'b1;
        if (fill_k_q == seq_len_m1[AW-1:0]) begin
          step_index_d = '0;
          step_rem_d   = entry0.length;
          running_d    = 1'b1;
          looping_d    = (kind_q == LD_EMERGENCY);
          pin_d        = entry0.level;
          state_d      = ST_EMIT;
        end else begin
          fill_k_d = fill_k_q + AW'(1);
        end
      end
      ST_RD: state_d = ST_APPLY;
      ST_APPLY: begin
        step_rem_d = ram_rdata.length;
        pin_d      = ram_rdata.level;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        // Hold the result until the output register frees up
        if (!out_valid_q || out_ready_i) begin
          out_valid_d             = 1'b1;
          out_data_d.buzzer_level = pin_q;
          out_data_d.busy_res     = running_q;
          state_d                 = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      seq_len_q    <= '0;
      step_index_q <= '0;
      step_rem_q   <= '0;
      running_q    <= 1'b0;
      looping_q    <= 1'b0;
      pulse_en_q   <= 1'b0;
      pulse_cnt_q  <= '0;
      pulse_snd_q  <= 1'b0;
      pin_q        <= 1'b0;
      kind_q       <= LD_BEEP;
      fill_k_q     <= '0;
      mul_hi_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      seq_len_q    <= seq_len_d;
      step_index_q <= step_index_d;
      step_rem_q   <= step_rem_d;
      running_q    <= running_d;
      looping_q    <= looping_d;
      pulse_en_q   <= pulse_en_d;
      pulse_cnt_q  <= pulse_cnt_d;
      pulse_snd_q  <= pulse_snd_d;
      pin_q        <= pin_d;
      kind_q       <= kind_d;
      fill_k_q     <= fill_k_d;
      mul_hi_q     <= mul_hi_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q      <= div_d;
    prod_lo_q  <= prod_lo_d;
    long_len_q <= long_len_d;
    out_data_q <= out_data_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // ---------------- assertions ----------------
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready stayed high after a command was taken");

  a_running_has_notes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q |-> seq_len_q != '0)
    else $error("sequence running with an empty note table");

  a_index_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q && state_q == ST_IDLE |-> step_index_q < seq_len_q)
    else $error("note index past the end of a running sequence");

endmodule
